// ===== design/lmss_pkg.sv =====
`default_nettype none

package lmss_pkg;

    // Scan phases. The two-bit code that has no member falls back to the clear phase.
    typedef enum logic [1:0] {
        PH_CLEAR = 2'd0,
        PH_SHIFT = 2'd1,
        PH_DWELL = 2'd2
    } phase_t;

    localparam int ROM_GLYPHS = 13;
    localparam int ROM_ROWS   = 7;
    localparam int MASK_W     = 7;
    localparam int ROM_BITS   = 5;

    localparam logic [MASK_W-1:0] ALL_OFF = 7'h7F;

    // Configuration register indexes, taken from paddr[2].
    localparam logic REG_FRAMES = 1'b0;
    localparam logic REG_DWELL  = 1'b1;

    localparam logic [15:0] FRAMES_RESET = 16'd8;
    localparam logic [15:0] DWELL_RESET  = 16'd250;

    typedef struct packed {
        logic [15:0] frames_per_scroll;
        logic [15:0] row_dwell_ticks;
    } cfg_t;

    typedef struct packed {
        logic              serial_data;
        logic              shift_strobe;
        logic [MASK_W-1:0] row_off_mask;
        logic              clear_shift;
        logic [3:0]        scroll_offset;
        logic              frame_end;
    } result_t;

    localparam logic [ROM_BITS-1:0] GLYPH_ROM [ROM_GLYPHS][ROM_ROWS] = '{
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h11, 5'h11, 5'h11, 5'h15, 5'h1B, 5'h1B, 5'h11},
        '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h0E},
        '{5'h11, 5'h13, 5'h13, 5'h15, 5'h19, 5'h19, 5'h11},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11},
        '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h0E},
        '{5'h1E, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
        '{5'h1E, 5'h09, 5'h09, 5'h09, 5'h09, 5'h09, 5'h1E},
        '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h0E},
        '{5'h1E, 5'h09, 5'h09, 5'h09, 5'h09, 5'h09, 5'h1E},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
        '{5'h0E, 5'h11, 5'h01, 5'h0E, 5'h10, 5'h11, 5'h0E}
    };

    // Glyph row bits, zero-extended to eight bits. Anything outside the table is blank.
    function automatic logic [7:0] glyph_bits(input logic [7:0] glyph, input logic [3:0] row);
        logic [7:0] bits;
        bits = '0;
        if (glyph < 8'(ROM_GLYPHS) && row < 4'(ROM_ROWS))
        begin
            bits = 8'(GLYPH_ROM[glyph[3:0]][row[2:0]]);
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

// ===== design/lmss_scan.sv =====
`default_nettype none

module lmss_scan
    import lmss_pkg::*;
#(
    parameter int CHARS_SHOWN = 16,
    parameter int GLYPH_COUNT = 13,
    parameter int ROW_COUNT   = 7,
    parameter int GLYPH_WIDTH = 5
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    step,
    input  wire logic    advance,
    input  wire cfg_t    cfg,
    output result_t      result
);

    localparam int CW  = (CHARS_SHOWN > 1) ? $clog2(CHARS_SHOWN) : 1;
    localparam int RW  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int BW  = $clog2(GLYPH_WIDTH + 1);
    localparam int GBW = $clog2(GLYPH_COUNT);

    phase_t              phase_reg, phase_next;
    logic [RW-1:0]       row_index_reg, row_index_next;
    logic [CW-1:0]       char_index_reg, char_index_next;
    logic [BW-1:0]       bit_index_reg, bit_index_next;
    logic [15:0]         dwell_count_reg, dwell_count_next;
    logic [15:0]         frame_count_reg, frame_count_next;
    logic [GBW-1:0]      base_glyph_reg, base_glyph_next;
    logic [GBW-1:0]      cur_glyph_reg, cur_glyph_next;
    logic [MASK_W-1:0]   row_drive_reg, row_drive_next;

    logic [7:0]          bits;
    logic [2:0]          bit_sel;
    logic [16:0]         dwell_sum;
    logic [16:0]         frame_sum;
    logic [15:0]         dwell_limit;
    logic [15:0]         frame_limit;
    logic                data;
    logic                strobe;
    logic                clr;
    logic                fend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_CLEAR;
            row_index_reg   <= '0;
            char_index_reg  <= '0;
            bit_index_reg   <= '0;
            dwell_count_reg <= '0;
            frame_count_reg <= '0;
            base_glyph_reg  <= '0;
            cur_glyph_reg   <= '0;
            row_drive_reg   <= ALL_OFF;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            row_index_reg   <= row_index_next;
            char_index_reg  <= char_index_next;
            bit_index_reg   <= bit_index_next;
            dwell_count_reg <= dwell_count_next;
            frame_count_reg <= frame_count_next;
            base_glyph_reg  <= base_glyph_next;
            cur_glyph_reg   <= cur_glyph_next;
            row_drive_reg   <= row_drive_next;
        end
    end

    // cur_glyph_reg tracks (base + char_index) mod GLYPH_COUNT, so no modulo is needed.
    assign bits        = glyph_bits(8'(cur_glyph_reg), 4'(row_index_reg));
    assign bit_sel     = 3'(GLYPH_WIDTH - 1 - int'(bit_index_reg));
    assign dwell_sum   = {1'b0, dwell_count_reg} + 17'd1;
    assign frame_sum   = {1'b0, frame_count_reg} + 17'd1;
    assign dwell_limit = (cfg.row_dwell_ticks == 16'd0) ? 16'd1 : cfg.row_dwell_ticks;
    assign frame_limit = (cfg.frames_per_scroll == 16'd0) ? 16'd1 : cfg.frames_per_scroll;

    always_comb
    begin
        phase_next       = phase_reg;
        row_index_next   = row_index_reg;
        char_index_next  = char_index_reg;
        bit_index_next   = bit_index_reg;
        dwell_count_next = dwell_count_reg;
        frame_count_next = frame_count_reg;
        base_glyph_next  = base_glyph_reg;
        cur_glyph_next   = cur_glyph_reg;
        row_drive_next   = row_drive_reg;
        data             = 1'b0;
        strobe           = 1'b0;
        clr              = 1'b0;
        fend             = 1'b0;

        if (advance)
        begin
            unique case (phase_reg)
                PH_SHIFT:
                begin
                    if (char_index_reg == '0 && bit_index_reg == '0)
                    begin
                        row_drive_next = ALL_OFF;
                    end
                    if (bit_index_reg < BW'(GLYPH_WIDTH))
                    begin
                        data = bits[bit_sel];
                    end
                    strobe = 1'b1;
                    if (bit_index_reg == BW'(GLYPH_WIDTH))
                    begin
                        // Spacer bit done: move on to the next character.
                        bit_index_next = '0;
                        if (char_index_reg == CW'(CHARS_SHOWN - 1))
                        begin
                            char_index_next  = '0;
                            phase_next       = PH_DWELL;
                            dwell_count_next = '0;
                            cur_glyph_next   = base_glyph_reg;
                        end
                        else
                        begin
                            char_index_next = char_index_reg + CW'(1);
                            cur_glyph_next  = (cur_glyph_reg == GBW'(GLYPH_COUNT - 1)) ?
                                              '0 : cur_glyph_reg + GBW'(1);
                        end
                    end
                    else
                    begin
                        bit_index_next = bit_index_reg + BW'(1);
                    end
                end

                PH_DWELL:
                begin
                    if (4'(row_index_reg) < 4'(MASK_W))
                    begin
                        row_drive_next = ALL_OFF & ~(MASK_W'(1) << row_index_reg);
                    end
                    else
                    begin
                        row_drive_next = ALL_OFF;
                    end
                    if (dwell_sum >= {1'b0, dwell_limit})
                    begin
                        dwell_count_next = '0;
                        phase_next       = PH_SHIFT;
                        if (row_index_reg == RW'(ROW_COUNT - 1))
                        begin
                            row_index_next = '0;
                            fend           = 1'b1;
                            if (frame_sum >= {1'b0, frame_limit})
                            begin
                                frame_count_next = '0;
                                base_glyph_next  = (base_glyph_reg == GBW'(GLYPH_COUNT - 1)) ?
                                                   '0 : base_glyph_reg + GBW'(1);
                                cur_glyph_next   = base_glyph_next;
                            end
                            else
                            begin
                                frame_count_next = frame_sum[15:0];
                            end
                        end
                        else
                        begin
                            row_index_next = row_index_reg + RW'(1);
                        end
                    end
                    else
                    begin
                        dwell_count_next = dwell_sum[15:0];
                    end
                end

                default:
                begin
                    clr              = 1'b1;
                    row_drive_next   = ALL_OFF;
                    phase_next       = PH_SHIFT;
                    row_index_next   = '0;
                    char_index_next  = '0;
                    bit_index_next   = '0;
                    dwell_count_next = '0;
                    cur_glyph_next   = base_glyph_reg;
                end
            endcase
        end

        result.serial_data   = data;
        result.shift_strobe  = strobe;
        result.row_off_mask  = row_drive_next;
        result.clear_shift   = clr;
        result.scroll_offset = 4'(base_glyph_reg);
        result.frame_end     = fend;
    end

endmodule

`default_nettype wire

// ===== design/led_matrix_scroll_scanner.sv =====
// Each result is registered in the output register, or in the skid register while the output is stalled.
// One input transfer per cycle while in_ready is high; the scan counters step once per transfer.
// A two-deep output stage (output register plus skid register) keeps in_ready registered.
// Reset (rst_n low, asynchronous) puts the scanner in its clear phase with all rows off,
// empties the output stage and loads the configuration defaults (8 frames, 250 ticks).
`default_nettype none

module led_matrix_scroll_scanner
    import lmss_pkg::*;
#(
    parameter int CHARS_SHOWN = 16,
    parameter int GLYPH_COUNT = 13,
    parameter int ROW_COUNT   = 7,
    parameter int GLYPH_WIDTH = 5
) (
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,

    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              advance,

    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   serial_data,
    output logic                   shift_strobe,
    output logic      [MASK_W-1:0] row_off_mask,
    output logic                   clear_shift,
    output logic      [3:0]        scroll_offset,
    output logic                   frame_end
);

    cfg_t    cfg_reg;
    result_t result;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    in_xfer;
    logic    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign in_ready  = !skid_valid_reg;
    assign in_xfer   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frames_per_scroll <= FRAMES_RESET;
            cfg_reg.row_dwell_ticks   <= DWELL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_FRAMES: cfg_reg.frames_per_scroll <= pwdata[15:0];
                REG_DWELL:  cfg_reg.row_dwell_ticks   <= pwdata[15:0];
                default:    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_FRAMES: prdata = {16'b0, cfg_reg.frames_per_scroll};
            REG_DWELL:  prdata = {16'b0, cfg_reg.row_dwell_ticks};
            default:    prdata = '0;
        endcase
    end

    lmss_scan #(
        .CHARS_SHOWN (CHARS_SHOWN),
        .GLYPH_COUNT (GLYPH_COUNT),
        .ROW_COUNT   (ROW_COUNT),
        .GLYPH_WIDTH (GLYPH_WIDTH)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (in_xfer),
        .advance (advance),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // A result goes to the output register when it is free or being drained,
    // otherwise it waits in the skid register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_xfer;
            end
        end
        else if (in_xfer)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_xfer)
            begin
                out_reg <= result;
            end
        end
        else if (in_xfer)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign serial_data   = out_reg.serial_data;
    assign shift_strobe  = out_reg.shift_strobe;
    assign row_off_mask  = out_reg.row_off_mask;
    assign clear_shift   = out_reg.clear_shift;
    assign scroll_offset = out_reg.scroll_offset;
    assign frame_end     = out_reg.frame_end;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while the output register is empty");

    a_data_needs_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && serial_data) |-> shift_strobe)
        else $error("serial data is high on a transfer without a shift strobe");

    a_clear_all_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clear_shift) |-> (row_off_mask == ALL_OFF && !shift_strobe && !frame_end))
        else $error("clear transfer does not have every row off");

endmodule

`default_nettype wire

// ===== sim/lmss_scan_checker.sv =====
module lmss_scan_checker
    import lmss_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    input  wire logic              pready,

    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic              advance,

    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic              serial_data,
    input  wire logic              shift_strobe,
    input  wire logic [MASK_W-1:0] row_off_mask,
    input  wire logic              clear_shift,
    input  wire logic [3:0]        scroll_offset,
    input  wire logic              frame_end,

    output int                     mismatches,
    output int                     outstanding
);

    localparam int CHARS   = 16;
    localparam int GLYPHS  = 13;
    localparam int ROWS    = 7;
    localparam int GLYPH_W = 5;

    logic [15:0]       frames_cfg;
    logic [15:0]       dwell_cfg;
    phase_t            scan_phase;
    int                row_idx;
    int                char_idx;
    int                bit_idx;
    int                dwell_cnt;
    int                frame_cnt;
    logic [3:0]        base_glyph;
    logic [MASK_W-1:0] row_drive;

    result_t           expected_outputs [$];
    result_t           want;
    result_t           got;
    int                fails;

    // Advances the scan state by one input transfer and returns the output it causes.
    function automatic result_t next_scan_output(input logic adv);
        result_t          r;
        int               glyph;
        int               limit;
        int               frame_len;
        logic [GLYPH_W-1:0] bits;
        r = '0;
        r.scroll_offset = base_glyph;
        if (adv)
        begin
            case (scan_phase)
                PH_SHIFT:
                begin
                    if (char_idx == 0 && bit_idx == 0)
                    begin
                        row_drive = ALL_OFF;
                    end
                    glyph = (int'(base_glyph) + char_idx) % GLYPHS;
                    bits = '0;
                    if (glyph < ROM_GLYPHS && row_idx < ROM_ROWS)
                    begin
                        bits = GLYPH_ROM[glyph][row_idx];
                    end
                    if (bit_idx < GLYPH_W)
                    begin
                        r.serial_data = bits[GLYPH_W - 1 - bit_idx];
                    end
                    r.shift_strobe = 1'b1;
                    bit_idx++;
                    if (bit_idx > GLYPH_W)
                    begin
                        bit_idx = 0;
                        char_idx++;
                        if (char_idx >= CHARS)
                        begin
                            char_idx = 0;
                            scan_phase = PH_DWELL;
                            dwell_cnt = 0;
                        end
                    end
                end
                PH_DWELL:
                begin
                    limit = (dwell_cfg == 16'd0) ? 1 : int'(dwell_cfg);
                    if (row_idx < MASK_W)
                    begin
                        row_drive = ALL_OFF & ~(7'd1 << row_idx);
                    end
                    else
                    begin
                        row_drive = ALL_OFF;
                    end
                    dwell_cnt++;
                    if (dwell_cnt >= limit)
                    begin
                        dwell_cnt = 0;
                        scan_phase = PH_SHIFT;
                        row_idx++;
                        if (row_idx >= ROWS)
                        begin
                            frame_len = (frames_cfg == 16'd0) ? 1 : int'(frames_cfg);
                            row_idx = 0;
                            r.frame_end = 1'b1;
                            frame_cnt++;
                            if (frame_cnt >= frame_len)
                            begin
                                frame_cnt = 0;
                                base_glyph = 4'((int'(base_glyph) + 1) % GLYPHS);
                            end
                        end
                    end
                end
                default:
                begin
                    // The unused phase code behaves like the clear phase.
                    r.clear_shift = 1'b1;
                    row_drive = ALL_OFF;
                    scan_phase = PH_SHIFT;
                    row_idx = 0;
                    char_idx = 0;
                    bit_idx = 0;
                    dwell_cnt = 0;
                end
            endcase
        end
        r.row_off_mask = row_drive;
        return r;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            fails++;
            if (fails <= 10)
            begin
                $display("mismatch on %s: expected %0d, got %0d", name, exp_val, act_val);
            end
        end
    endtask

    always_comb
    begin
        got.serial_data   = serial_data;
        got.shift_strobe  = shift_strobe;
        got.row_off_mask  = row_off_mask;
        got.clear_shift   = clear_shift;
        got.scroll_offset = scroll_offset;
        got.frame_end     = frame_end;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_cfg = FRAMES_RESET;
            dwell_cfg  = DWELL_RESET;
            scan_phase = PH_CLEAR;
            row_idx    = 0;
            char_idx   = 0;
            bit_idx    = 0;
            dwell_cnt  = 0;
            frame_cnt  = 0;
            base_glyph = '0;
            row_drive  = ALL_OFF;
            fails      = 0;
            expected_outputs.delete();
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            // Results are registered in the output stage before they leave, so the oldest expectation is
            // always queued before the matching output transfer.
            if (out_valid && out_ready)
            begin
                if (expected_outputs.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                    begin
                        $display("result with nothing expected: mask %0h offset %0d",
                                 row_off_mask, scroll_offset);
                    end
                end
                else
                begin
                    want = expected_outputs.pop_front();
                    check_field("serial_data", want.serial_data, got.serial_data);
                    check_field("shift_strobe", want.shift_strobe, got.shift_strobe);
                    check_field("row_off_mask", want.row_off_mask, got.row_off_mask);
                    check_field("clear_shift", want.clear_shift, got.clear_shift);
                    check_field("scroll_offset", want.scroll_offset, got.scroll_offset);
                    check_field("frame_end", want.frame_end, got.frame_end);
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_DWELL)
                begin
                    dwell_cfg = pwdata[15:0];
                end
                else
                begin
                    frames_cfg = pwdata[15:0];
                end
            end
            if (in_valid && in_ready)
            begin
                expected_outputs.push_back(next_scan_output(advance));
            end
            outstanding <= expected_outputs.size();
            mismatches  <= fails;
        end
    end

endmodule

// ===== sim/led_matrix_scroll_scanner_tb.sv =====
module led_matrix_scroll_scanner_tb;

    import lmss_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              advance = 1'b0;

    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              serial_data;
    logic              shift_strobe;
    logic [MASK_W-1:0] row_off_mask;
    logic              clear_shift;
    logic [3:0]        scroll_offset;
    logic              frame_end;

    int                mismatches;
    int                outstanding;
    int                cycles = 0;
    logic              calm = 1'b0;
    logic              squeeze_req = 1'b0;

    led_matrix_scroll_scanner DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .serial_data   (serial_data),
        .shift_strobe  (shift_strobe),
        .row_off_mask  (row_off_mask),
        .clear_shift   (clear_shift),
        .scroll_offset (scroll_offset),
        .frame_end     (frame_end)
    );

    lmss_scan_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .serial_data   (serial_data),
        .shift_strobe  (shift_strobe),
        .row_off_mask  (row_off_mask),
        .clear_shift   (clear_shift),
        .scroll_offset (scroll_offset),
        .frame_end     (frame_end),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, a calm stretch, and one long hold-off on request.
    initial
    begin
        int  hold_left;
        logic squeeze_done;
        hold_left = 0;
        squeeze_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze_req && !squeeze_done)
            begin
                squeeze_done = 1'b1;
                hold_left = 150;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (calm)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= 22);
            end
        end
    end

    // Holds the tick on the input until its transfer; returns at that clock edge.
    task automatic send_tick(input logic adv);
        in_valid <= 1'b1;
        advance  <= adv;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic write_reg(input logic reg_sel, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {16'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stops offering ticks and waits until every expected result has been seen.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic run_ticks(input int count, input int calm_from, input int calm_to);
        for (int k = 0; k < count; k++)
        begin
            calm = (k >= calm_from && k < calm_to);
            while (!calm && $urandom_range(0, 99) < 22)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            send_tick($urandom_range(0, 99) < 85);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        logic [24:0] opening;
        // Holds before and after the clear step, then the first shift steps with holds mixed in.
        opening = 25'b1111110011111101111110100;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < 25; k++)
        begin
            send_tick(opening[k]);
        end
        settle();

        // Zero in both registers acts as one: fastest scan, long enough for a whole
        // frame and one step of the text.
        write_reg(REG_FRAMES, 16'd0);
        write_reg(REG_DWELL, 16'd0);
        run_ticks(1050, 300, 500);
        settle();

        write_reg(REG_FRAMES, 16'hFFFF);
        write_reg(REG_DWELL, 16'hFFFF);
        squeeze_req = 1'b1;
        run_ticks(125, -1, -1);
        settle();

        write_reg(REG_FRAMES, 16'd2);
        write_reg(REG_DWELL, 16'($urandom_range(1, 30)));
        run_ticks(125, -1, -1);
        settle();

        write_reg(REG_DWELL, 16'($urandom_range(1, 12)));
        write_reg(REG_FRAMES, 16'($urandom_range(1, 4)));
        run_ticks(75, -1, -1);
        settle();

        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
